/* sv/rcsd_pkg.sv */
// Package with shared types, constants and state codes of the SUMH frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rcsd_pkg;

  // Frame layout and decoding constants.
  localparam int unsigned FRAME_LEN     = 21;
  localparam int unsigned LAST_SLOT     = FRAME_LEN - 1;
  localparam int unsigned MARKER_SLOT   = 19;
  localparam int unsigned FIRST_CHAN    = 3;
  localparam logic [7:0]  HEADER_BYTE   = 8'hA8;
  localparam logic [13:0] VALUE_OFFSET  = 14'd375;
  localparam logic [19:0] GAP_RESET     = 20'd5000;
  localparam int unsigned CHANNELS_DEF  = 8;
  localparam int unsigned QUEUE_DEF     = 2;
  localparam logic [13:0] VALUE_MAX     = 14'd9864;

  // One received byte with its arrival timestamp.
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] time_us;
  } in_word_t;

  // One decoded result.
  typedef struct packed {
    logic [2:0]  channel_index;
    logic [13:0] channel_value;
    logic        frame_valid;
    logic        last;
  } out_word_t;

  // Command from the front end to the back end: store a byte, and maybe check the frame.
  typedef struct packed {
    logic [4:0] addr;
    logic [7:0] data;
    logic       check;
    logic       ok;
  } cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CALC,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

/* sv/rc_sumh_frame_decoder.sv */
// Top level of the SUMH receiver frame decoder.
//
// Input channel (in_valid, in_stall, in_word): one received byte with its
// microsecond timestamp per word. A gap above the configured limit restarts
// the frame at slot 0. The byte that fills slot 20 triggers a frame check.
// Output channel (out_valid, out_stall, out_word): a good frame gives one
// word per channel, the last one flagged; a bad frame gives one rejection
// word. Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the gap
// limit; cfg_ready is always high.
// The front end takes one byte per cycle, while the queue is not full, into a
// short command queue. The back end stores each byte as it pops it; after a
// completed good frame it walks the channels through store read, scaling
// multiply and output for each, and pops no further command until the last
// channel word is registered. While the back end is busy the queue fills
// and in_stall rises once it is full.
// Reset (synchronous) clears the position, the previous timestamp, the queue
// and the output valid flag, and sets the gap limit to 5000 us. When the
// receiver stalls, the output word holds and the back end waits.
`timescale 1ns / 1ps
`default_nettype none

module rc_sumh_frame_decoder #(
  parameter int unsigned CHANNELS    = rcsd_pkg::CHANNELS_DEF,
  parameter int unsigned QUEUE_DEPTH = rcsd_pkg::QUEUE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rcsd_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rcsd_pkg::out_word_t      out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [19:0]         cfg_data
);

  rcsd_pkg::q_status_t q_status;
  rcsd_pkg::cmd_t      push_cmd;
  rcsd_pkg::cmd_t      pop_cmd;
  logic                push;
  logic                pop;

  rcsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rcsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  rcsd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* sv/rcsd_front.sv */
// Front end: gap detection, write position tracking and frame check flags.
`timescale 1ns / 1ps
`default_nettype none

module rcsd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rcsd_pkg::in_word_t  in_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [19:0]         cfg_data,
  input  wire rcsd_pkg::q_status_t q_status,
  output logic                     push,
  output rcsd_pkg::cmd_t           push_cmd
);

  logic [19:0] gap_limit;
  logic [4:0]  pos;
  logic [31:0] prev_time;
  logic        hdr_ok;
  logic        mark_ok;
  logic [31:0] gap;
  logic [4:0]  slot;
  logic        accept;

  // The byte waits only when the queue towards the back end is full.
  assign in_stall  = q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Wrapping gap since the previous byte; a long gap restarts the frame.
  assign gap  = in_word.time_us - prev_time;
  assign slot = (gap > {12'd0, gap_limit}) ? 5'd0 : pos;

  // Command for the back end.
  assign push          = accept;
  assign push_cmd.addr = slot;
  assign push_cmd.data = in_word.rx_byte;
  assign push_cmd.check = (slot == 5'(rcsd_pkg::LAST_SLOT));
  assign push_cmd.ok   = hdr_ok && mark_ok;

  // Position, timestamp and check flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= rcsd_pkg::GAP_RESET;
      pos       <= 5'd0;
      prev_time <= 32'd0;
      hdr_ok    <= 1'b0;
      mark_ok   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_limit <= cfg_data;
      end
      if (accept) begin
        prev_time <= in_word.time_us;
        if (slot == 5'(rcsd_pkg::LAST_SLOT)) begin
          pos <= slot;
        end else begin
          pos <= slot + 5'd1;
        end
        if (slot == 5'd0) begin
          hdr_ok <= (in_word.rx_byte == rcsd_pkg::HEADER_BYTE);
        end
        if (slot == 5'(rcsd_pkg::MARKER_SLOT)) begin
          mark_ok <= (in_word.rx_byte == 8'd0);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/rcsd_queue.sv */
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module rcsd_queue #(
  parameter int unsigned DEPTH = rcsd_pkg::QUEUE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rcsd_pkg::cmd_t      push_cmd,
  input  wire logic                pop,
  output rcsd_pkg::cmd_t           pop_cmd,
  output rcsd_pkg::q_status_t      q_status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rcsd_pkg::cmd_t entry [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign q_status.empty = (count == CW'(0));
  assign q_status.full  = (count == CW'(DEPTH));
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_cmd = entry[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/rcsd_back.sv */
// Back end: frame store, channel decoding sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

module rcsd_back #(
  parameter int unsigned CHANNELS = rcsd_pkg::CHANNELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rcsd_pkg::q_status_t q_status,
  input  wire rcsd_pkg::cmd_t      pop_cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rcsd_pkg::out_word_t      out_word
);

  logic [7:0]            store [rcsd_pkg::FRAME_LEN];
  rcsd_pkg::back_state_t state;
  rcsd_pkg::back_state_t state_next;
  logic [2:0]            chan;
  logic [7:0]            rd_hi;
  logic [7:0]            rd_lo;
  logic [13:0]           scaled;
  logic [18:0]           product;
  logic [4:0]            addr_hi;
  logic [4:0]            addr_lo;
  logic                  out_free;
  logic                  emit_rej;
  logic                  emit_chan;
  logic                  last_chan;

  // The output register can take a new word when empty or being drained.
  assign out_free  = !out_valid || !out_stall;
  assign last_chan = (chan == 3'(CHANNELS - 1));
  assign addr_hi   = 5'(rcsd_pkg::FIRST_CHAN) + {1'b0, chan, 1'b0};
  assign addr_lo   = addr_hi + 5'd1;
  assign product   = {3'd0, rd_hi, rd_lo} * 19'd5;

  // Sequencer: store each byte; on a check, walk the channels or emit a rejection.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit_rej   = 1'b0;
    emit_chan  = 1'b0;
    case (state)
      rcsd_pkg::BK_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop = 1'b1;
          if (pop_cmd.check) begin
            if (pop_cmd.ok) begin
              state_next = rcsd_pkg::BK_READ;
            end else begin
              emit_rej = 1'b1;
            end
          end
        end
      end
      rcsd_pkg::BK_READ: begin
        state_next = rcsd_pkg::BK_CALC;
      end
      rcsd_pkg::BK_CALC: begin
        state_next = rcsd_pkg::BK_EMIT;
      end
      rcsd_pkg::BK_EMIT: begin
        if (out_free) begin
          emit_chan  = 1'b1;
          state_next = last_chan ? rcsd_pkg::BK_IDLE : rcsd_pkg::BK_READ;
        end
      end
      default: begin
        state_next = rcsd_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcsd_pkg::BK_IDLE;
      out_valid <= 1'b0;
      chan      <= 3'd0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit_rej || emit_chan) begin
        out_valid <= 1'b1;
      end
      if (pop) begin
        chan <= 3'd0;
      end else if (emit_chan) begin
        chan <= chan + 3'd1;
      end
    end
  end

  // Frame store, read data, scaling and the output word.
  always_ff @(posedge clk) begin
    if (pop) begin
      store[pop_cmd.addr] <= pop_cmd.data;
    end
    if (state == rcsd_pkg::BK_READ) begin
      rd_hi <= store[addr_hi];
      rd_lo <= store[addr_lo];
    end
    if (state == rcsd_pkg::BK_CALC) begin
      scaled <= product[18:5];
    end
    if (emit_rej) begin
      out_word.channel_index <= 3'd0;
      out_word.channel_value <= 14'd0;
      out_word.frame_valid   <= 1'b0;
      out_word.last          <= 1'b1;
    end else if (emit_chan) begin
      out_word.channel_index <= chan;
      out_word.channel_value <= (scaled > rcsd_pkg::VALUE_OFFSET) ?
                                (scaled - rcsd_pkg::VALUE_OFFSET) : 14'd0;
      out_word.frame_valid   <= 1'b1;
      out_word.last          <= last_chan;
    end
  end

endmodule

`default_nettype wire

/* sv/rcsd_checker.sv */
// Port-level checks of the SUMH frame decoder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rcsd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire rcsd_pkg::in_word_t  in_word,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire rcsd_pkg::out_word_t out_word,
  input wire logic                cfg_valid,
  input wire logic                cfg_ready,
  input wire logic [19:0]         cfg_data
);

  // A stalled result word holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // No result word is offered straight after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A rejection is a single, empty, final word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.frame_valid |->
      out_word.last && out_word.channel_index == 3'd0 &&
      out_word.channel_value == 14'd0)
    else $error("malformed rejection word");

  // Decoded values never exceed the largest possible pulse value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.frame_valid |-> out_word.channel_value <= rcsd_pkg::VALUE_MAX)
    else $error("channel value out of range");

endmodule

bind rc_sumh_frame_decoder rcsd_checker u_checker (.*);

`default_nettype wire
